[sv/blp4_pkg.sv]
package blp4_pkg;

	localparam int TAPS = 4;

	// item queue between front and back, power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Q3.29 coefficients, feed-forward side is symmetric (b0 b1 b2 b1 b0)
	localparam logic signed [24:0] COEF_B0 = 25'sd2590050;
	localparam logic signed [24:0] COEF_B1 = 25'sd10360198;
	localparam logic signed [24:0] COEF_B2 = 25'sd15540298;
	localparam logic signed [31:0] COEF_A1 = -32'sd1272122609;
	localparam logic signed [31:0] COEF_A2 = 32'sd1242313070;
	localparam logic signed [31:0] COEF_A3 = -32'sd566219178;
	localparam logic signed [31:0] COEF_A4 = 32'sd100598599;

	typedef logic signed [15:0] xtap_t;
	typedef logic signed [31:0] ytap_t;

	typedef struct packed {
		logic [1:0]         channel;
		logic signed [15:0] sample;
	} item_t;

endpackage

[sv/blp4_front.sv]
module blp4_front import blp4_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic [1:0]  s_axis_tuser,   // [1:0] channel
	output item_t       head,
	output logic        head_valid,
	input  logic        pop
);

	item_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	item_t              in_item;
	logic               in_range;
	logic               push;

	assign in_item.channel = s_axis_tuser;
	assign in_item.sample  = s_axis_tdata;

	// items for channels that do not exist are taken and dropped
	assign in_range      = 32'(s_axis_tuser) < CHANNELS;
	assign s_axis_tready = cnt_q != QCNT_W'(QDEPTH);
	assign push          = s_axis_tvalid && s_axis_tready && in_range;

	assign head       = entries_q[rd_ptr_q];
	assign head_valid = cnt_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("queue count lost a push");

endmodule

[sv/blp4_back.sv]
module blp4_back import blp4_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  logic        head_valid,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] filtered
	output logic [2:0]  m_axis_tuser    // [1:0] out_channel, [2] clipped
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	xtap_t              xh_q [CHANNELS][TAPS];
	ytap_t              yh_q [CHANNELS][TAPS];

	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic signed [16:0] sum04;
	logic signed [16:0] sum13;
	logic signed [41:0] pb [3];
	logic signed [63:0] pa [TAPS];

	logic               s1_valid_q;
	logic [1:0]         ch_s1;
	xtap_t              x0_s1;
	logic signed [41:0] pb_s1 [3];
	logic signed [63:0] pa_s1 [TAPS];

	logic               out_valid_q;
	logic [1:0]         out_ch_q;
	logic [15:0]        out_filt_q;
	logic               out_clip_q;

	logic               out_rdy;
	logic               s1_adv;
	logic               hazard;
	logic               retire;

	logic signed [43:0] bsum;
	logic signed [66:0] acc;
	logic [37:0]        y_fl;
	logic               y_pos;
	logic               y_neg;
	ytap_t              y_sat;
	logic signed [32:0] osum;
	logic [16:0]        o_fl;
	logic               o_pos;
	logic               o_neg;
	logic [15:0]        o_sat;

	// ---- handshake between stages
	assign out_rdy = !out_valid_q || m_axis_tready;
	assign s1_adv  = !s1_valid_q || out_rdy;
	assign retire  = s1_valid_q && out_rdy;
	// new y of the channel in s1 is not written back yet
	assign hazard  = s1_valid_q && (ch_s1 == head.channel);
	assign pop     = head_valid && s1_adv && !hazard;

	assign rd_idx = IDX_W'(head.channel);
	assign wr_idx = IDX_W'(ch_s1);

	// ---- s1: history read and products
	always_comb begin
		sum04 = 17'(head.sample) + 17'(xh_q[rd_idx][3]);
		sum13 = 17'(xh_q[rd_idx][0]) + 17'(xh_q[rd_idx][2]);
		pb[0] = 42'(sum04) * 42'(COEF_B0);
		pb[1] = 42'(sum13) * 42'(COEF_B1);
		pb[2] = 42'(xh_q[rd_idx][1]) * 42'(COEF_B2);
		pa[0] = 64'(yh_q[rd_idx][0]) * 64'(COEF_A1);
		pa[1] = 64'(yh_q[rd_idx][1]) * 64'(COEF_A2);
		pa[2] = 64'(yh_q[rd_idx][2]) * 64'(COEF_A3);
		pa[3] = 64'(yh_q[rd_idx][3]) * 64'(COEF_A4);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ch_s1 <= head.channel;
			x0_s1 <= head.sample;
			pb_s1 <= pb;
			pa_s1 <= pa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= pop;
		end
	end

	// ---- s2: sum, round to Q16.16, saturate, round to integer and saturate
	always_comb begin
		bsum = 44'(pb_s1[0]) + 44'(pb_s1[1]) + 44'(pb_s1[2]);
		acc  = (67'(bsum) <<< 16) - 67'(pa_s1[0]) - 67'(pa_s1[1])
			- 67'(pa_s1[2]) - 67'(pa_s1[3]) + (67'sd1 <<< 28);
		y_fl  = acc[66:29];
		y_pos = !y_fl[37] && (|y_fl[36:31]);
		y_neg = y_fl[37] && !(&y_fl[36:31]);
		if (y_pos) begin
			y_sat = 32'sh7FFF_FFFF;
		end else if (y_neg) begin
			y_sat = 32'sh8000_0000;
		end else begin
			y_sat = y_fl[31:0];
		end
		osum  = 33'(y_sat) + 33'sd32768;
		o_fl  = osum[32:16];
		o_pos = !o_fl[16] && o_fl[15];
		o_neg = o_fl[16] && !o_fl[15];
		if (o_pos) begin
			o_sat = 16'h7FFF;
		end else if (o_neg) begin
			o_sat = 16'h8000;
		end else begin
			o_sat = o_fl[15:0];
		end
	end

	// history shifts when the item leaves s2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < TAPS; k++) begin
					xh_q[c][k] <= '0;
					yh_q[c][k] <= '0;
				end
			end
		end else if (retire) begin
			for (int k = TAPS - 1; k > 0; k--) begin
				xh_q[wr_idx][k] <= xh_q[wr_idx][k-1];
				yh_q[wr_idx][k] <= yh_q[wr_idx][k-1];
			end
			xh_q[wr_idx][0] <= x0_s1;
			yh_q[wr_idx][0] <= y_sat;
		end
	end

	// ---- output register
	always_ff @(posedge clk) begin
		if (retire) begin
			out_ch_q   <= ch_s1;
			out_filt_q <= o_sat;
			out_clip_q <= y_pos || y_neg || o_pos || o_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_rdy) begin
			out_valid_q <= s1_valid_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_filt_q;
	assign m_axis_tuser  = {out_clip_q, out_ch_q};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_rdy) |=> (s1_valid_q && ch_s1 == $past(ch_s1)))
		else $error("stalled s1 item lost");

	a_same_ch_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !(pop && head.channel == $past(head.channel)))
		else $error("same channel issued before feedback written");

	// a clipped item always leaves on one of the output rails
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2])
			|-> (m_axis_tdata == 16'h7FFF || m_axis_tdata == 16'h8000))
		else $error("clipped item not on a rail");

	a_y_clip_rails_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (y_pos || y_neg)) |-> (o_sat == 16'h7FFF || o_sat == 16'h8000))
		else $error("saturated history did not saturate output");

endmodule

[sv/butterworth_lowpass_iir4_core.sv]
// channel   dir  valid/ready                  tdata                tuser
// s_axis    in   s_axis_tvalid/s_axis_tready  [15:0] sample        [1:0] channel
// m_axis    out  m_axis_tvalid/m_axis_tready  [15:0] filtered      [1:0] out_channel, [2] clipped
//
// One item per cycle while channels alternate and the output does not stall;
// two items of the same channel in a row leave a bubble, set by the feedback loop
// from the adder stage back into the y-history multipliers.
// Reset clears all history flops at once; no clearing pass.
// Items with a channel at or above CHANNELS are taken and dropped.
// Output stalls fill the 4-entry queue before s_axis_tready drops.
module butterworth_lowpass_iir4_core import blp4_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic [1:0]  s_axis_tuser,   // [1:0] channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] filtered
	output logic [2:0]  m_axis_tuser    // [1:0] out_channel, [2] clipped
);

	item_t head;
	logic  head_valid;
	logic  pop;

	blp4_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	blp4_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
